// ----- design/tcs_pkg.sv -----
// Shared types and constants for the tagged counter stack.
package tcs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned CNT_W  = 16;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_INC    = 3'd3,
    OP_DEC    = 3'd4,
    OP_TOPVAL = 3'd5,
    OP_KEYVAL = 3'd6,
    OP_CLEAR  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    execute;
    logic    commit;
    status_e status;
  } tcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic found;
    logic top_match;
  } tcs_stat_t;

endpackage

// ----- design/tagged_counter_stack_core.sv -----
// A word is latched in the capture step, then executed on the register file; the result word
// is registered at execute. No new word is taken while one is executing.
// A waiting result does not block a new word; a stalled result holds the input off.
// Reset (rst_ni, asynchronous, active low) empties the stack and drops any result.
// Entry contents are not cleared by reset; only entries below the fill level are read.
// Top level of the tagged counter stack.
module tagged_counter_stack_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       op_i,
  input  logic [tcs_pkg::KEY_W-1:0]        key_i,
  input  logic signed [tcs_pkg::CNT_W-1:0] start_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [tcs_pkg::CNT_W-1:0] count_o,
  output logic [tcs_pkg::IDX_W-1:0]        position_o,
  output logic [tcs_pkg::FILL_W-1:0]       fill_o
);
  import tcs_pkg::*;

  tcs_cmd_t  cmd;
  tcs_stat_t stat;

  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .key_i         (key_i),
    .start_count_i (start_count_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .count_o       (count_o),
    .position_o    (position_o),
    .fill_o        (fill_o)
  );

endmodule

// ----- design/tcs_ctrl.sv -----
// Controller: handshake, sequencing and error decode for the counter stack.
module tcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tcs_pkg::tcs_stat_t stat_i,
  output tcs_pkg::tcs_cmd_t  cmd_o
);
  import tcs_pkg::*;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  status_e err;
  logic    accept;

  // Hold the input while busy or while a stalled result word waits
  assign in_stall_o = (state_q == S_EXEC) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Decode the outcome of the latched operation
  always_comb begin
    err = ST_OK;
    case (stat_i.op) inside
      OP_PUSH: begin
        if (stat_i.full) err = ST_FULL;
      end
      OP_POP, OP_INC, OP_DEC: begin
        if (stat_i.empty) err = ST_EMPTY;
      end
      OP_REMOVE, OP_KEYVAL: begin
        if (stat_i.empty)       err = ST_EMPTY;
        else if (!stat_i.found) err = ST_NOTFOUND;
      end
      OP_TOPVAL: begin
        if (stat_i.empty)           err = ST_EMPTY;
        else if (!stat_i.top_match) err = ST_NOTFOUND;
      end
      default: err = ST_OK;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.commit = cmd_o.execute && (err == ST_OK);
    cmd_o.status = err;
  end

  // Load the result word on execute, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute)     out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/tcs_dpath.sv -----
// Datapath: entry register file, key compare, shift-down and result word.
module tcs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [2:0]                          op_i,
  input  logic [tcs_pkg::KEY_W-1:0]           key_i,
  input  logic signed [tcs_pkg::CNT_W-1:0]    start_count_i,
  input  tcs_pkg::tcs_cmd_t                   cmd_i,
  output tcs_pkg::tcs_stat_t                  stat_o,
  output logic [1:0]                          status_o,
  output logic signed [tcs_pkg::CNT_W-1:0]    count_o,
  output logic [tcs_pkg::IDX_W-1:0]           position_o,
  output logic [tcs_pkg::FILL_W-1:0]          fill_o
);
  import tcs_pkg::*;

  op_e                      op_q;
  logic [KEY_W-1:0]         key_q;
  logic signed [CNT_W-1:0]  start_q;
  logic [FILL_W-1:0]        used_q, used_d;

  logic [KEY_W-1:0]         key_mem [DEPTH];
  logic signed [CNT_W-1:0]  cnt_mem [DEPTH];

  logic [DEPTH-1:0]         match;
  logic [IDX_W-1:0]         hit_idx;
  logic [FILL_W-1:0]        top_w;
  logic [IDX_W-1:0]         top;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [CNT_W-1:0]  rd_cnt;
  logic signed [CNT_W-1:0]  bumped;
  logic [IDX_W-1:0]         pos;
  logic signed [CNT_W-1:0]  cnt_res;

  logic [1:0]               status_q;
  logic signed [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]         pos_q;
  logic [FILL_W-1:0]        fill_q;

  // Compare every held entry against the key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (FILL_W'(i) < used_q) && (key_mem[i] == key_q);
    end
  end

  // Lowest matching entry
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end

  assign top_w = used_q - FILL_W'(1);
  assign top   = top_w[IDX_W-1:0];

  // Single count read port: matched entry for key lookup, top otherwise
  assign rd_addr = (op_q == OP_KEYVAL) ? hit_idx : top;
  assign rd_cnt  = cnt_mem[rd_addr];

  // Saturating step of the top count
  always_comb begin
    bumped = rd_cnt;
    if (op_q == OP_INC) begin
      if (rd_cnt != CNT_MAX) bumped = rd_cnt + CNT_W'(1);
    end else begin
      if (rd_cnt != CNT_MIN) bumped = rd_cnt - CNT_W'(1);
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = (used_q == '0);
  assign stat_o.full      = (used_q == FILL_W'(DEPTH));
  assign stat_o.found     = |match;
  assign stat_o.top_match = (key_mem[top] == key_q);

  // Result fields and new fill level
  always_comb begin
    pos     = '0;
    cnt_res = '0;
    used_d  = used_q;
    case (op_q)
      OP_PUSH:   pos = used_q[IDX_W-1:0];
      OP_POP:    pos = top;
      OP_REMOVE: pos = hit_idx;
      OP_INC:    pos = top;
      OP_DEC:    pos = top;
      OP_TOPVAL: begin
        pos     = top;
        cnt_res = rd_cnt;
      end
      OP_KEYVAL: begin
        pos     = hit_idx;
        cnt_res = rd_cnt;
      end
      default: pos = '0;
    endcase
    if (cmd_i.status != ST_OK) begin
      pos     = '0;
      cnt_res = '0;
    end
    if (cmd_i.commit) begin
      case (op_q)
        OP_PUSH:   used_d = used_q + FILL_W'(1);
        OP_POP:    used_d = top_w;
        OP_REMOVE: used_d = top_w;
        OP_CLEAR:  used_d = '0;
        default:   used_d = used_q;
      endcase
    end
  end

  // Fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Latch the operation word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      key_q   <= key_i;
      start_q <= start_count_i;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q <= cmd_i.status;
      count_q  <= cnt_res;
      pos_q    <= pos;
      fill_q   <= used_d;
    end
  end

  // Entry store: push, count update, shift-down on remove
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      case (op_q)
        OP_PUSH: begin
          key_mem[used_q[IDX_W-1:0]] <= key_q;
          cnt_mem[used_q[IDX_W-1:0]] <= start_q;
        end
        OP_INC, OP_DEC: begin
          cnt_mem[top] <= bumped;
        end
        OP_REMOVE: begin
          for (int j = 0; j < DEPTH - 1; j++) begin
            if (IDX_W'(j) >= hit_idx) begin
              key_mem[j] <= key_mem[j+1];
              cnt_mem[j] <= cnt_mem[j+1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o   = status_q;
  assign count_o    = count_q;
  assign position_o = pos_q;
  assign fill_o     = fill_q;

endmodule

// ----- design/tcs_checker.sv -----
// Port-level checks for the tagged counter stack, bound to the top level.
module tcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [1:0]                       status_o,
  input logic signed [tcs_pkg::CNT_W-1:0] count_o,
  input logic [tcs_pkg::IDX_W-1:0]        position_o,
  input logic [tcs_pkg::FILL_W-1:0]       fill_o
);
  import tcs_pkg::*;

  // Block is busy in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while executing");

  // Fill never exceeds the depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_o <= FILL_W'(DEPTH)))
    else $error("fill beyond depth");

  // Errors carry no position and no count
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (position_o == '0 && count_o == '0))
    else $error("error word with position or count");

  // Full only reported with a full stack
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (fill_o == FILL_W'(DEPTH)))
    else $error("full status below depth");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(count_o) && $stable(position_o) && $stable(fill_o)))
    else $error("stalled result changed");

endmodule

bind tagged_counter_stack_core tcs_checker u_tcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .count_o     (count_o),
  .position_o  (position_o),
  .fill_o      (fill_o)
);
